### rtl/core/tscp_pkg.sv
// ----------------------------------------------------------------------------
// tscp_pkg: shared definitions for the time set command parser
// Character codes, limits, the grammar phase type and the result record.
// ----------------------------------------------------------------------------
package tscp_pkg;

  localparam int FRAME_BYTES_DEFAULT = 32;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam logic [7:0] ACC_INVALID = 8'd255;
  localparam logic [7:0] MAX_HOURS   = 8'd23;
  localparam logic [7:0] MAX_MIN_SEC = 8'd59;

  typedef enum logic [1:0] {
    OUTCOME_ERROR = 2'd0,
    OUTCOME_TIME  = 2'd1,
    OUTCOME_ALARM = 2'd2
  } outcome_t;

  typedef enum logic [9:0] {
    PH_OPEN    = 10'b0000000001,
    PH_TYPE    = 10'b0000000010,
    PH_COMMA   = 10'b0000000100,
    PH_H_FIRST = 10'b0000001000,
    PH_H_MORE  = 10'b0000010000,
    PH_M_FIRST = 10'b0000100000,
    PH_M_MORE  = 10'b0001000000,
    PH_S_FIRST = 10'b0010000000,
    PH_S_MORE  = 10'b0100000000,
    PH_DONE    = 10'b1000000000
  } phase_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } result_t;

endpackage

### rtl/core/tscp_parser.sv
// ----------------------------------------------------------------------------
// tscp_parser: frame grammar and field accumulation
// Holds the parse state and updates it from one registered byte per cycle while step is high.
// ----------------------------------------------------------------------------
module tscp_parser #(
  parameter int FRAME_BYTES = tscp_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output tscp_pkg::result_t res
);

  localparam int CW = $clog2(FRAME_BYTES);
  localparam logic [CW-1:0] KEEP_LIMIT = CW'(FRAME_BYTES - 1);

  tscp_pkg::phase_t parse_phase, parse_phase_next;
  logic [CW-1:0]    stored_count, stored_count_next;
  logic [7:0]       digit_accumulator, digit_accumulator_next;
  logic [7:0]       held_hours, held_hours_next;
  logic [7:0]       held_minutes, held_minutes_next;
  logic             alarm_kind, alarm_kind_next;
  logic             frame_error, frame_error_next;

  always_comb begin
    tscp_pkg::phase_t ph;
    logic [CW-1:0]    cnt;
    logic [7:0]       acc;
    logic [7:0]       hh;
    logic [7:0]       mm;
    logic             ak;
    logic             err;
    logic             digit;
    logic [7:0]       dval;
    logic             ok;

    ph    = parse_phase;
    cnt   = stored_count;
    acc   = digit_accumulator;
    hh    = held_hours;
    mm    = held_minutes;
    ak    = alarm_kind;
    err   = frame_error;
    digit = (rx_byte >= tscp_pkg::CH_ZERO) && (rx_byte <= tscp_pkg::CH_NINE);
    dval  = rx_byte - tscp_pkg::CH_ZERO;
    ok    = 1'b0;
    res   = '0;
    res_valid = 1'b0;

    if (step && rx_byte != tscp_pkg::CH_CR && rx_byte != tscp_pkg::CH_LF) begin
      if (rx_byte == tscp_pkg::CH_OPEN) begin
        ph  = tscp_pkg::PH_OPEN;
        cnt = '0;
        acc = '0;
        err = 1'b0;
      end

      if (cnt < KEEP_LIMIT) begin
        cnt = cnt + 1'b1;
        if (!err) begin
          unique case (ph)
            tscp_pkg::PH_OPEN: begin
              if (rx_byte == tscp_pkg::CH_OPEN) ph = tscp_pkg::PH_TYPE;
              else err = 1'b1;
            end
            tscp_pkg::PH_TYPE: begin
              if (rx_byte == tscp_pkg::CH_T || rx_byte == tscp_pkg::CH_A) begin
                ak = (rx_byte == tscp_pkg::CH_A);
                ph = tscp_pkg::PH_COMMA;
              end else begin
                err = 1'b1;
              end
            end
            tscp_pkg::PH_COMMA: begin
              if (rx_byte == tscp_pkg::CH_COMMA) ph = tscp_pkg::PH_H_FIRST;
              else err = 1'b1;
            end
            tscp_pkg::PH_H_FIRST, tscp_pkg::PH_M_FIRST, tscp_pkg::PH_S_FIRST: begin
              if (digit) begin
                acc = dval;
                if (ph == tscp_pkg::PH_H_FIRST) ph = tscp_pkg::PH_H_MORE;
                else if (ph == tscp_pkg::PH_M_FIRST) ph = tscp_pkg::PH_M_MORE;
                else ph = tscp_pkg::PH_S_MORE;
              end else begin
                err = 1'b1;
              end
            end
            tscp_pkg::PH_H_MORE, tscp_pkg::PH_M_MORE, tscp_pkg::PH_S_MORE: begin
              if (digit) begin
                // acc * 10 + digit, kept to eight bits
                acc = {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + dval;
              end else if (acc == tscp_pkg::ACC_INVALID) begin
                err = 1'b1;
              end else if (ph == tscp_pkg::PH_H_MORE && rx_byte == tscp_pkg::CH_COMMA) begin
                hh = acc;
                ph = tscp_pkg::PH_M_FIRST;
              end else if (ph == tscp_pkg::PH_M_MORE && rx_byte == tscp_pkg::CH_COMMA) begin
                mm = acc;
                ph = tscp_pkg::PH_S_FIRST;
              end else if (ph == tscp_pkg::PH_S_MORE && rx_byte == tscp_pkg::CH_CLOSE) begin
                ph = tscp_pkg::PH_DONE;
              end else begin
                err = 1'b1;
              end
            end
            default: err = 1'b1;
          endcase
        end
      end else if (rx_byte == tscp_pkg::CH_CLOSE) begin
        err = 1'b1;
      end

      if (rx_byte == tscp_pkg::CH_CLOSE) begin
        res_valid = 1'b1;
        ok = !err && ph == tscp_pkg::PH_DONE && acc != tscp_pkg::ACC_INVALID &&
             hh <= tscp_pkg::MAX_HOURS && mm <= tscp_pkg::MAX_MIN_SEC &&
             acc <= tscp_pkg::MAX_MIN_SEC;
        if (ok) begin
          res.outcome = ak ? tscp_pkg::OUTCOME_ALARM : tscp_pkg::OUTCOME_TIME;
          res.hours   = hh[4:0];
          res.minutes = mm[5:0];
          res.seconds = acc[5:0];
        end
        ph  = tscp_pkg::PH_OPEN;
        cnt = '0;
        acc = '0;
        err = 1'b0;
      end
    end

    parse_phase_next       = ph;
    stored_count_next      = cnt;
    digit_accumulator_next = acc;
    held_hours_next        = hh;
    held_minutes_next      = mm;
    alarm_kind_next        = ak;
    frame_error_next       = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= tscp_pkg::PH_OPEN;
      stored_count      <= '0;
      digit_accumulator <= '0;
      held_hours        <= '0;
      held_minutes      <= '0;
      alarm_kind        <= 1'b0;
      frame_error       <= 1'b0;
    end else begin
      parse_phase       <= parse_phase_next;
      stored_count      <= stored_count_next;
      digit_accumulator <= digit_accumulator_next;
      held_hours        <= held_hours_next;
      held_minutes      <= held_minutes_next;
      alarm_kind        <= alarm_kind_next;
      frame_error       <= frame_error_next;
    end
  end

  // A closing parenthesis always leaves a fresh, empty frame behind.
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    step && rx_byte == tscp_pkg::CH_CLOSE |=>
      parse_phase == tscp_pkg::PH_OPEN && stored_count == '0 && !frame_error)
    else $error("frame not cleared after closing parenthesis");

  // The kept-byte count never passes the frame limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    stored_count <= KEEP_LIMIT)
    else $error("stored byte count beyond frame limit");

  // Line ends leave the grammar untouched.
  a_line_end_ignored: assert property (@(posedge clk) disable iff (rst)
    step && (rx_byte == tscp_pkg::CH_CR || rx_byte == tscp_pkg::CH_LF) |=>
      $stable(parse_phase) && $stable(stored_count) && $stable(digit_accumulator))
    else $error("line end altered the parse state");

endmodule

### rtl/core/tscp_out_reg.sv
// ----------------------------------------------------------------------------
// tscp_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tscp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tscp_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        outcome,
  output logic [4:0]        hours,
  output logic [5:0]        minutes,
  output logic [5:0]        seconds
);

  tscp_pkg::result_t held;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign outcome = held.outcome;
  assign hours   = held.hours;
  assign minutes = held.minutes;
  assign seconds = held.seconds;

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !load)
    else $error("result register loaded while a result was stalled");

endmodule

### rtl/core/time_set_command_parser_top.sv
// ----------------------------------------------------------------------------
// time_set_command_parser_top: time and alarm set command parser
// Parses "(T,h,m,s)" and "(A,h,m,s)" frames from a byte stream and gives one
// result (set time, set alarm or error) for every closing parenthesis.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   rx_byte
//   result    out        out_valid / out_stall outcome, hours, minutes, seconds
//
// One byte is taken every cycle while in_stall is low. Each byte first lands
// in an input register; the parser then updates its state from it and, for a
// closing parenthesis, writes the result register, which offers the result
// on out_valid until the result side takes it. Reset is synchronous and
// returns the parser to waiting for an opening parenthesis. A stall on the
// result side holds the input register only when it carries a closing
// parenthesis and the result register is still occupied; all other bytes
// keep flowing.
//
module time_set_command_parser_top #(
  parameter int FRAME_BYTES = tscp_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] outcome,
  output logic [4:0] hours,
  output logic [5:0] minutes,
  output logic [5:0] seconds
);

  // Input register stage.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // The registered byte moves on unless it would produce a result that the
  // result register cannot yet take.
  logic              s1_move;
  logic              res_free;
  logic              res_valid;
  tscp_pkg::result_t res;

  assign s1_move  = !s1_valid || s1_byte != tscp_pkg::CH_CLOSE || res_free;
  assign in_stall = !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_move) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  // The grammar is stepped once for each beat leaving the input register.
  tscp_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_valid && s1_move),
    .rx_byte   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  tscp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .free      (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .outcome   (outcome),
    .hours     (hours),
    .minutes   (minutes),
    .seconds   (seconds)
  );

  // An accepted beat is always held in the input register next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted beat missing from input register");

  // A held closing parenthesis only waits behind a stalled result.
  a_hold_reason: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_byte == tscp_pkg::CH_CLOSE && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule
